FILE: rtl/owbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package owbm_pkg;

  // Width of the timing counter and of every timing register
  localparam int unsigned CountW = 10;

  // Width of the configuration register index
  localparam int unsigned CfgIdxW = 3;

  // Released ticks before the line is checked during reset
  localparam logic [CountW-1:0] ReleaseCheckUs = CountW'(5);

  // Command codes carried in req_type
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_RESET = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SHORT_LOW      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_LONG_LOW       = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_WRITE_SLOT     = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_READ_SAMPLE    = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CFG_READ_SLOT      = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW      = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE_SAMPLE = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] CFG_RECOVERY       = CfgIdxW'(7);

  // Last tick index of an interval; a zero length acts as one tick
  function automatic logic [CountW-1:0] last_tick(input logic [CountW-1:0] len);
    return (len == '0) ? '0 : CountW'(len - CountW'(1));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/owbm_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Tick channel: command, byte to send and sampled bus level
interface owbm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] write_data;
  logic       line_level;

  modport source (output valid, output req_type, output write_data, output line_level,
                  input ready);
  modport sink   (input valid, input req_type, input write_data, input line_level,
                  output ready);
endinterface

// Result channel: one result per tick
interface owbm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       presence;
  logic       cmd_rejected;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output read_byte, output presence, output cmd_rejected, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input read_byte, input presence, input cmd_rejected, output ready);
endinterface

// Configuration write channel
interface owbm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [owbm_pkg::CfgIdxW-1:0]   index;
  logic [owbm_pkg::CountW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/onewire_bus_master.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields                                            Transaction
// in_i     in   req_type, write_data, line_level                  valid & ready
// out_o    out  drive_low, busy_res, done_res, read_byte,         valid & ready
//               presence, cmd_rejected
// cfg_i    in   index, data                                       valid & ready
//
// One tick transaction per clock while in_i.ready is high; its result is in the
// output register in the next cycle. The whole tick update (phase, counter, shift
// byte) is one combinational pass from the state registers into the state and result
// registers. in_i.ready is low only while a result waits and out_o.ready is low.
// cfg_i is always ready. rst_ni clears control state and loads the default timings.

module onewire_bus_master (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  owbm_in_if.sink         in_i,
  owbm_out_if.source      out_o,
  owbm_cfg_if.sink        cfg_i
);

  localparam int unsigned CW = owbm_pkg::CountW;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RST_LOW   = 3'd1,
    PH_RST_CHECK = 3'd2,
    PH_RST_PRES  = 3'd3,
    PH_RST_RECOV = 3'd4,
    PH_WRITE     = 3'd5,
    PH_READ      = 3'd6
  } phase_e;

  // Timing registers
  logic [CW-1:0] short_low_q, long_low_q, write_slot_q, read_sample_q;
  logic [CW-1:0] read_slot_q, reset_low_q, pres_sample_q, recovery_q;

  // Operation state
  phase_e        phase_q, phase_d;
  logic [CW-1:0] tick_q, tick_d;
  logic [2:0]    bit_idx_q, bit_idx_d;
  logic [7:0]    shift_q, shift_d;
  logic          pres_q, pres_d;
  logic [7:0]    rd_result_q, rd_result_d;

  // Output register
  logic          out_valid_q;
  logic          drive_q, busy_q, done_q, rej_q;
  logic          drive_d, busy_d, done_d, rej_d;

  logic          in_accept;
  owbm_pkg::req_e req;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_accept   = in_i.valid && in_i.ready;
  assign req         = owbm_pkg::req_e'(in_i.req_type);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_low_q   <= CW'(6);
      long_low_q    <= CW'(60);
      write_slot_q  <= CW'(70);
      read_sample_q <= CW'(17);
      read_slot_q   <= CW'(87);
      reset_low_q   <= CW'(510);
      pres_sample_q <= CW'(60);
      recovery_q    <= CW'(420);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        owbm_pkg::CFG_SHORT_LOW:       short_low_q   <= cfg_i.data;
        owbm_pkg::CFG_LONG_LOW:        long_low_q    <= cfg_i.data;
        owbm_pkg::CFG_WRITE_SLOT:      write_slot_q  <= cfg_i.data;
        owbm_pkg::CFG_READ_SAMPLE:     read_sample_q <= cfg_i.data;
        owbm_pkg::CFG_READ_SLOT:       read_slot_q   <= cfg_i.data;
        owbm_pkg::CFG_RESET_LOW:       reset_low_q   <= cfg_i.data;
        owbm_pkg::CFG_PRESENCE_SAMPLE: pres_sample_q <= cfg_i.data;
        owbm_pkg::CFG_RECOVERY:        recovery_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // One tick of bus timing
  always_comb begin
    phase_e        ph;
    logic [CW-1:0] t;
    logic [CW-1:0] rd_end;
    logic [CW-1:0] rd_smp;
    logic          wbit;

    ph          = phase_q;
    t           = tick_q;
    bit_idx_d   = bit_idx_q;
    shift_d     = shift_q;
    pres_d      = pres_q;
    rd_result_d = rd_result_q;
    drive_d     = 1'b0;
    done_d      = 1'b0;
    rej_d       = 1'b0;

    // Command start or rejection
    if (ph == PH_IDLE) begin
      if (req != owbm_pkg::REQ_TICK) begin
        t         = '0;
        bit_idx_d = '0;
        unique case (req)
          owbm_pkg::REQ_RESET: begin
            ph     = PH_RST_LOW;
            pres_d = 1'b0;
          end
          owbm_pkg::REQ_WRITE: begin
            ph      = PH_WRITE;
            shift_d = in_i.write_data;
          end
          default: begin
            ph      = PH_READ;
            shift_d = '0;
          end
        endcase
      end
    end else if (req != owbm_pkg::REQ_TICK) begin
      rej_d = 1'b1;
    end

    busy_d  = (ph != PH_IDLE);
    phase_d = ph;
    tick_d  = t;

    wbit   = shift_d[bit_idx_d];
    rd_end = owbm_pkg::last_tick(read_slot_q);
    rd_smp = (read_sample_q > rd_end) ? rd_end : read_sample_q;

    unique case (ph)
      PH_RST_LOW: begin
        drive_d = 1'b1;
        if (t >= owbm_pkg::last_tick(reset_low_q)) begin
          phase_d = PH_RST_CHECK;
          tick_d  = '0;
        end else begin
          tick_d = CW'(t + CW'(1));
        end
      end
      PH_RST_CHECK: begin
        if (t >= owbm_pkg::ReleaseCheckUs) begin
          if (!in_i.line_level) begin
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_RST_PRES;
            tick_d  = '0;
          end
        end else begin
          tick_d = CW'(t + CW'(1));
        end
      end
      PH_RST_PRES: begin
        if (t >= owbm_pkg::last_tick(pres_sample_q)) begin
          tick_d = '0;
          if (!in_i.line_level) begin
            pres_d = 1'b1;
            if (recovery_q == '0) begin
              done_d  = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_RST_RECOV;
            end
          end else begin
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end
        end else begin
          tick_d = CW'(t + CW'(1));
        end
      end
      PH_RST_RECOV: begin
        if (t >= owbm_pkg::last_tick(recovery_q)) begin
          done_d  = 1'b1;
          phase_d = PH_IDLE;
          tick_d  = '0;
        end else begin
          tick_d = CW'(t + CW'(1));
        end
      end
      PH_WRITE: begin
        drive_d = (t < (wbit ? short_low_q : long_low_q));
        if (t >= owbm_pkg::last_tick(write_slot_q)) begin
          tick_d = '0;
          if (bit_idx_d == 3'd7) begin
            done_d    = 1'b1;
            phase_d   = PH_IDLE;
            bit_idx_d = '0;
          end else begin
            bit_idx_d = 3'(bit_idx_d + 3'd1);
          end
        end else begin
          tick_d = CW'(t + CW'(1));
        end
      end
      PH_READ: begin
        drive_d = (t < short_low_q);
        if (t == rd_smp && in_i.line_level) begin
          shift_d[bit_idx_d] = 1'b1;
        end
        if (t >= rd_end) begin
          tick_d = '0;
          if (bit_idx_d == 3'd7) begin
            rd_result_d = shift_d;
            done_d      = 1'b1;
            phase_d     = PH_IDLE;
            bit_idx_d   = '0;
          end else begin
            bit_idx_d = 3'(bit_idx_d + 3'd1);
          end
        end else begin
          tick_d = CW'(t + CW'(1));
        end
      end
      default: begin
        // idle, or an unused code that falls back to idle
        phase_d = PH_IDLE;
      end
    endcase
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_idx_q   <= '0;
      shift_q     <= '0;
      pres_q      <= 1'b0;
      rd_result_q <= '0;
      out_valid_q <= 1'b0;
      drive_q     <= 1'b0;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      rej_q       <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_q     <= phase_d;
        tick_q      <= tick_d;
        bit_idx_q   <= bit_idx_d;
        shift_q     <= shift_d;
        pres_q      <= pres_d;
        rd_result_q <= rd_result_d;
        drive_q     <= drive_d;
        busy_q      <= busy_d;
        done_q      <= done_d;
        rej_q       <= rej_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.drive_low    = drive_q;
  assign out_o.busy_res     = busy_q;
  assign out_o.done_res     = done_q;
  assign out_o.read_byte    = rd_result_q;
  assign out_o.presence     = pres_q;
  assign out_o.cmd_rejected = rej_q;

endmodule

`default_nettype wire

FILE: rtl/owbm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module owbm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       drive_i,
  input wire logic       busy_i,
  input wire logic       done_i,
  input wire logic       rej_i,
  input wire logic [7:0] read_byte_i
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_byte_i)
      && $stable(done_i) && $stable(drive_i))
    else $error("stalled result changed");

  // An empty output register never blocks a tick
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // Bus is only pulled low while an operation runs
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && drive_i |-> busy_i)
    else $error("drive low while idle");

  // Completion and rejection only happen on busy ticks
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (done_i || rej_i) |-> busy_i)
    else $error("done or reject while idle");

  // Every accepted tick yields a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted tick gave no result");

endmodule

bind onewire_bus_master owbm_checker u_owbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .drive_i     (out_o.drive_low),
  .busy_i      (out_o.busy_res),
  .done_i      (out_o.done_res),
  .rej_i       (out_o.cmd_rejected),
  .read_byte_i (out_o.read_byte)
);

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import owbm_pkg::*;

  // Bus sequencing phases of the predictor
  typedef enum logic [2:0] {
    BUS_IDLE,
    RST_LOW,
    RST_CHECK,
    RST_PRES,
    RST_RECOV,
    WR_SLOT,
    RD_SLOT
  } bus_phase_e;

  // Line stimulus styles for one operation
  typedef enum int {
    LINE_RANDOM,
    LINE_MOSTLY_HIGH,
    LINE_MOSTLY_LOW,
    LINE_HIGH,
    LINE_LOW
  } line_mode_e;

  // One result transaction
  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [7:0] read_byte;
    logic       presence;
    logic       rejected;
  } tick_res_t;

  // Tick-level model of the bus master plus the queue of results it predicts
  class tick_scoreboard;
    logic [CountW-1:0] timing [8];
    bus_phase_e        ph;
    logic [CountW-1:0] cnt;
    logic [2:0]        bit_idx;
    logic [7:0]        shreg;
    logic [7:0]        rd_byte;
    logic              pres;
    tick_res_t         expected_ticks [$];
    int                errors;

    function new();
      timing[CFG_SHORT_LOW]       = 6;
      timing[CFG_LONG_LOW]        = 60;
      timing[CFG_WRITE_SLOT]      = 70;
      timing[CFG_READ_SAMPLE]     = 17;
      timing[CFG_READ_SLOT]       = 87;
      timing[CFG_RESET_LOW]       = 510;
      timing[CFG_PRESENCE_SAMPLE] = 60;
      timing[CFG_RECOVERY]        = 420;
      ph = BUS_IDLE;
      cnt = '0;
      bit_idx = '0;
      shreg = '0;
      rd_byte = '0;
      pres = 1'b0;
      errors = 0;
    endfunction

    function void set_timing(logic [CfgIdxW-1:0] idx, logic [CountW-1:0] val);
      timing[idx] = val;
    endfunction

    // Final tick of an interval; a zero length still takes one tick
    function logic [CountW-1:0] span_end(logic [CountW-1:0] len);
      return (len == '0) ? '0 : len - 1'b1;
    endfunction

    function bit busy();
      return ph != BUS_IDLE;
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    // Advance the model by one accepted tick and queue its result
    function void predict_tick(req_e req, logic [7:0] data, logic line);
      tick_res_t         r;
      logic [CountW-1:0] t;
      logic [CountW-1:0] slot_end;
      logic [CountW-1:0] sample_at;
      logic              cur_bit;
      r = '0;
      if (ph == BUS_IDLE) begin
        if (req != REQ_TICK) begin
          cnt = '0;
          bit_idx = '0;
          case (req)
            REQ_RESET: begin
              ph = RST_LOW;
              pres = 1'b0;
            end
            REQ_WRITE: begin
              ph = WR_SLOT;
              shreg = data;
            end
            default: begin
              ph = RD_SLOT;
              shreg = '0;
            end
          endcase
        end
      end else if (req != REQ_TICK) begin
        r.rejected = 1'b1;
      end

      t = cnt;
      r.busy = (ph != BUS_IDLE);
      case (ph)
        RST_LOW: begin
          r.drive_low = 1'b1;
          if (t >= span_end(timing[CFG_RESET_LOW])) begin
            ph = RST_CHECK;
            cnt = '0;
          end else cnt = t + 1'b1;
        end
        RST_CHECK: begin
          // bus still held low after release: nobody can answer
          if (t >= ReleaseCheckUs) begin
            if (!line) begin
              r.done = 1'b1;
              ph = BUS_IDLE;
            end else begin
              ph = RST_PRES;
              cnt = '0;
            end
          end else cnt = t + 1'b1;
        end
        RST_PRES: begin
          if (t >= span_end(timing[CFG_PRESENCE_SAMPLE])) begin
            cnt = '0;
            if (!line) begin
              pres = 1'b1;
              if (timing[CFG_RECOVERY] == '0) begin
                r.done = 1'b1;
                ph = BUS_IDLE;
              end else ph = RST_RECOV;
            end else begin
              r.done = 1'b1;
              ph = BUS_IDLE;
            end
          end else cnt = t + 1'b1;
        end
        RST_RECOV: begin
          if (t >= span_end(timing[CFG_RECOVERY])) begin
            r.done = 1'b1;
            ph = BUS_IDLE;
            cnt = '0;
          end else cnt = t + 1'b1;
        end
        WR_SLOT: begin
          cur_bit = shreg[bit_idx];
          r.drive_low = t < (cur_bit ? timing[CFG_SHORT_LOW] : timing[CFG_LONG_LOW]);
          if (t >= span_end(timing[CFG_WRITE_SLOT])) begin
            cnt = '0;
            if (bit_idx == 3'd7) begin
              r.done = 1'b1;
              ph = BUS_IDLE;
            end
            bit_idx = bit_idx + 1'b1;
          end else cnt = t + 1'b1;
        end
        RD_SLOT: begin
          r.drive_low = t < timing[CFG_SHORT_LOW];
          slot_end = span_end(timing[CFG_READ_SLOT]);
          // sample point clamps to the last tick of the slot
          sample_at = (timing[CFG_READ_SAMPLE] > slot_end) ? slot_end
                                                           : timing[CFG_READ_SAMPLE];
          if (t == sample_at && line) shreg[bit_idx] = 1'b1;
          if (t >= slot_end) begin
            cnt = '0;
            if (bit_idx == 3'd7) begin
              rd_byte = shreg;
              r.done = 1'b1;
              ph = BUS_IDLE;
            end
            bit_idx = bit_idx + 1'b1;
          end else cnt = t + 1'b1;
        end
        default: ;
      endcase
      r.read_byte = rd_byte;
      r.presence = pres;
      expected_ticks.push_back(r);
    endfunction

    function void check_tick(tick_res_t got);
      tick_res_t exp_r;
      if (expected_ticks.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing expected: drive=%0b busy=%0b done=%0b byte=%02h pres=%0b rej=%0b",
                   $realtime, got.drive_low, got.busy, got.done, got.read_byte,
                   got.presence, got.rejected);
        return;
      end
      exp_r = expected_ticks.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch exp drive=%0b busy=%0b done=%0b byte=%02h pres=%0b rej=%0b",
                   $realtime, exp_r.drive_low, exp_r.busy, exp_r.done, exp_r.read_byte,
                   exp_r.presence, exp_r.rejected);
          $display("%0t:          got drive=%0b busy=%0b done=%0b byte=%02h pres=%0b rej=%0b",
                   $realtime, got.drive_low, got.busy, got.done, got.read_byte,
                   got.presence, got.rejected);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  owbm_in_if  in_if ();
  owbm_out_if out_if ();
  owbm_cfg_if cfg_if ();

  onewire_bus_master i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  tick_scoreboard    chk;
  int                idle_pct;
  bit                hold_req;
  int                items_sent;
  logic [CountW-1:0] next_timing [8];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: check every transaction, stall in bursts or for one long hold
  initial begin
    int        stall_left;
    tick_res_t got;
    stall_left = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.drive_low = out_if.drive_low;
        got.busy      = out_if.busy_res;
        got.done      = out_if.done_res;
        got.read_byte = out_if.read_byte;
        got.presence  = out_if.presence;
        got.rejected  = out_if.cmd_rejected;
        chk.check_tick(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 400;
      end else if (stall_left == 0 && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one tick and wait for its transaction
  task automatic send_item(input req_e req, input logic [7:0] data, input logic line);
    in_if.valid      <= 1'b1;
    in_if.req_type   <= req;
    in_if.write_data <= data;
    in_if.line_level <= line;
    do @(posedge clk_i); while (!in_if.ready);
    chk.predict_tick(req, data, line);
    items_sent++;
  endtask

  task automatic maybe_gap();
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  function automatic logic pick_line(line_mode_e mode);
    case (mode)
      LINE_MOSTLY_HIGH: return $urandom_range(9) != 0;
      LINE_MOSTLY_LOW:  return $urandom_range(9) == 0;
      LINE_HIGH:        return 1'b1;
      LINE_LOW:         return 1'b0;
      default:          return $urandom_range(1);
    endcase
  endfunction

  // Tick until the operation ends, now and then poking in a command
  task automatic finish_op(input line_mode_e mode);
    req_e rq;
    while (chk.busy()) begin
      rq = ($urandom_range(19) == 0) ? req_e'($urandom_range(1, 3)) : REQ_TICK;
      send_item(rq, 8'($urandom), pick_line(mode));
      maybe_gap();
    end
  endtask

  task automatic run_op(input req_e cmd, input line_mode_e mode, input logic [7:0] data);
    send_item(cmd, data, pick_line(mode));
    maybe_gap();
    finish_op(mode);
  endtask

  // Mostly complete operations, some idle ticks in between
  task automatic run_random(input int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(REQ_TICK, 8'($urandom), $urandom_range(1));
        maybe_gap();
      end else begin
        run_op(req_e'($urandom_range(1, 3)), line_mode_e'($urandom_range(4)), 8'($urandom));
      end
    end
  endtask

  // Wait until every predicted result has been seen
  task automatic settle();
    in_if.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_timing();
    logic [CfgIdxW-1:0] idx;
    for (int i = 0; i < 8; i++) begin
      idx = CfgIdxW'(i);
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= next_timing[idx];
      do @(posedge clk_i); while (!cfg_if.ready);
      chk.set_timing(idx, next_timing[idx]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_all_timing(input logic [CountW-1:0] val);
    for (int i = 0; i < 8; i++) next_timing[i] = val;
  endtask

  // Power-up timing values
  task automatic set_default_timing();
    next_timing[CFG_SHORT_LOW]       = CountW'(6);
    next_timing[CFG_LONG_LOW]        = CountW'(60);
    next_timing[CFG_WRITE_SLOT]      = CountW'(70);
    next_timing[CFG_READ_SAMPLE]     = CountW'(17);
    next_timing[CFG_READ_SLOT]       = CountW'(87);
    next_timing[CFG_RESET_LOW]       = CountW'(510);
    next_timing[CFG_PRESENCE_SAMPLE] = CountW'(60);
    next_timing[CFG_RECOVERY]        = CountW'(420);
  endtask

  // Short random timings so operations finish in tens of ticks
  task automatic set_small_timing();
    next_timing[CFG_SHORT_LOW]       = CountW'($urandom_range(0, 4));
    next_timing[CFG_LONG_LOW]        = CountW'($urandom_range(0, 8));
    next_timing[CFG_WRITE_SLOT]      = CountW'($urandom_range(1, 10));
    next_timing[CFG_READ_SAMPLE]     = CountW'($urandom_range(0, 10));
    next_timing[CFG_READ_SLOT]       = CountW'($urandom_range(1, 10));
    next_timing[CFG_RESET_LOW]       = CountW'($urandom_range(0, 8));
    next_timing[CFG_PRESENCE_SAMPLE] = CountW'($urandom_range(0, 8));
    next_timing[CFG_RECOVERY]        = CountW'($urandom_range(0, 6));
  endtask

  initial begin
    chk = new();
    idle_pct = 10;
    hold_req = 1'b0;
    items_sent = 0;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.req_type   <= REQ_TICK;
    in_if.write_data <= '0;
    in_if.line_level <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CFG_SHORT_LOW;
    cfg_if.data      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: power-up timings with a short reset pulse
    set_default_timing();
    next_timing[CFG_RESET_LOW] = CountW'(12);
    write_timing();
    send_item(REQ_TICK, 8'h00, 1'b0);
    send_item(REQ_TICK, 8'hFF, 1'b1);
    send_item(REQ_RESET, 8'h5A, 1'b1);
    // commands while busy are dropped
    send_item(REQ_WRITE, 8'hFF, 1'b1);
    send_item(REQ_READ, 8'h00, 1'b0);
    send_item(REQ_RESET, 8'hFF, 1'b1);
    finish_op(LINE_HIGH);
    run_op(REQ_RESET, LINE_LOW, 8'hC3);
    settle();

    // Zero lengths behave as one tick; no recovery wait
    set_all_timing('0);
    write_timing();
    run_random(60);
    settle();

    // Single-tick timings
    set_all_timing(CountW'(1));
    next_timing[CFG_RECOVERY] = '0;
    write_timing();
    run_random(60);
    settle();

    // Low times past the slot end, sample point past the read slot
    next_timing[CFG_SHORT_LOW]       = CountW'(9);
    next_timing[CFG_LONG_LOW]        = CountW'(9);
    next_timing[CFG_WRITE_SLOT]      = CountW'(4);
    next_timing[CFG_READ_SAMPLE]     = CountW'(20);
    next_timing[CFG_READ_SLOT]       = CountW'(5);
    next_timing[CFG_RESET_LOW]       = CountW'(3);
    next_timing[CFG_PRESENCE_SAMPLE] = CountW'(2);
    next_timing[CFG_RECOVERY]        = CountW'(3);
    write_timing();
    run_random(60);
    settle();

    // Random short timings; first phase holds off the result side for a while
    for (int ph_i = 0; ph_i < 4; ph_i++) begin
      set_small_timing();
      write_timing();
      if (ph_i == 0) hold_req = 1'b1;
      run_random(50);
      settle();
    end

    // Last stretch runs at full rate
    idle_pct = 0;
    set_small_timing();
    write_timing();
    run_random(80);
    settle();

    repeat (20) @(posedge clk_i);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
